// ===== design/utc2gps_pkg.sv =====
// Shared types, constants and tables for the UTC to GPS week/second converter.
// No dependencies; imported by utc_to_gps_week_seconds_top.
`timescale 1ns / 1ps

package utc2gps_pkg;

	// Input and output words
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} utc_time_t;

	typedef struct packed {
		logic [16:0] gps_week;
		logic [19:0] week_second;
		logic        before_epoch;
	} gps_time_t;

	// Internal widths
	localparam int TOD_W  = 17;   // hh*3600 + mm*60 + ss, up to 115443
	localparam int DAY_W  = 21;   // signed day count from the GPS epoch
	localparam int WEEK_W = 17;
	localparam int SOW_W  = 20;
	localparam int TAI_W  = 6;

	// Calendar and time constants
	localparam int GPS_EPOCH_JDN = 2444244;
	localparam int MJD_BASE      = 2400000;
	localparam int EPOCH_MJD     = GPS_EPOCH_JDN - MJD_BASE;
	localparam int SEC_PER_DAY   = 86400;
	localparam int SEC_PER_HOUR  = 3600;
	localparam int SEC_PER_MIN   = 60;
	localparam int TAI_GPS_SEC   = 19;
	localparam int FIRST_TAI_UTC = 10;
	localparam int YEAR_BIAS     = 4716;
	localparam int JDN_YEAR_MUL  = 1461;
	// jdn = yterm + mterm + d + (2 - a + a/4) - 1525, taken relative to the epoch
	localparam int DAY_BIAS      = GPS_EPOCH_JDN + 1525 - 2;

	// Reciprocal constants: floor(x/100) for x < 4096, floor(x/7) for x < 2^20
	localparam int DIV100_SHIFT = 19;
	localparam int DIV100_MUL   = (2 ** DIV100_SHIFT) / 100 + 1;
	localparam int DIV7_SHIFT   = 23;
	localparam int DIV7_MUL     = (2 ** DIV7_SHIFT) / 7 + 1;

	// Leap-second table
	localparam int LEAP_TABLE_SIZE = 28;
	localparam int LEAP_ENTRIES    = 28;
	localparam int LEAP_USED       = (LEAP_ENTRIES < LEAP_TABLE_SIZE) ?
		LEAP_ENTRIES : LEAP_TABLE_SIZE;

	localparam int LEAP_MJD [LEAP_TABLE_SIZE] = '{
		41317, 41499, 41683, 42048, 42413, 42778, 43144, 43509, 43874, 44239,
		44786, 45151, 45516, 46247, 47161, 47892, 48257, 48804, 49169, 49534,
		50083, 50630, 51179, 53736, 54832, 56109, 57204, 57754
	};

	localparam logic [TAI_W-1:0] LEAP_TAI_UTC [LEAP_TABLE_SIZE] = '{
		6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
		6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37
	};

	// floor(30.6001 * (m' + 1)), where January and February (and month 0)
	// count as months 13, 14 and 12 of the previous year
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] t;
		case (m)
			4'd0:    t = 9'd397;
			4'd1:    t = 9'd428;
			4'd2:    t = 9'd459;
			4'd3:    t = 9'd122;
			4'd4:    t = 9'd153;
			4'd5:    t = 9'd183;
			4'd6:    t = 9'd214;
			4'd7:    t = 9'd244;
			4'd8:    t = 9'd275;
			4'd9:    t = 9'd306;
			4'd10:   t = 9'd336;
			4'd11:   t = 9'd367;
			4'd12:   t = 9'd397;
			4'd13:   t = 9'd428;
			4'd14:   t = 9'd459;
			default: t = 9'd489;
		endcase
		return t;
	endfunction

endpackage

// ===== design/utc_to_gps_week_seconds_top.sv =====
// UTC calendar date and time to GPS week and second of week, eight-stage pipeline.
// Throughput: one word per cycle; a stall at the output holds every stage while gps_valid is high.
// Reset clears the stage valid bits only; no other state is kept.
// Depends on utc2gps_pkg.
`timescale 1ns / 1ps

module utc_to_gps_week_seconds_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   utc_valid,
	output logic                   utc_stall,
	input  utc2gps_pkg::utc_time_t utc,
	output logic                   gps_valid,
	input  logic                   gps_stall,
	output utc2gps_pkg::gps_time_t gps
);
	import utc2gps_pkg::*;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;

	// Stage 1: year/month shift, month term, time of day
	logic              early_c;
	logic signed [12:0] ya_c;
	logic [TOD_W-1:0]  tod_c;
	logic signed [12:0] ya_s1;
	logic [8:0]        mterm_s1;
	logic [4:0]        day_s1;
	logic [TOD_W-1:0]  tod_s1;

	// Stage 2: century term and year term
	logic [11:0]       ya_pos_c;
	logic [24:0]       a_prod_c;
	logic [13:0]       yb_c;
	logic [24:0]       y_prod_c;
	logic [5:0]        a_s2;
	logic [21:0]       yterm_s2;
	logic [8:0]        mterm_s2;
	logic [4:0]        day_s2;
	logic [TOD_W-1:0]  tod_s2;

	// Stage 3: day count from epoch
	logic [23:0]       day_c;
	logic signed [DAY_W-1:0] day_s3;
	logic              nd_s3;
	logic [TOD_W-1:0]  tod_s3;

	// Stage 4: leap table compare
	logic signed [DAY_W:0] day_eff_c;
	logic [LEAP_TABLE_SIZE-1:0] hit_c;
	logic [LEAP_TABLE_SIZE-1:0] hit_s4;
	logic signed [DAY_W-1:0] day_s4;
	logic [TOD_W-1:0]  tod_s4;

	// Stage 5: TAI-UTC select
	logic [TAI_W-1:0]  off_c;
	logic [TAI_W-1:0]  off_s5;
	logic signed [DAY_W-1:0] day_s5;
	logic [TOD_W-1:0]  tod_s5;

	// Stage 6: second of day and day carry
	logic signed [17:0] sv_c;
	logic [TOD_W-1:0]  sod_c;
	logic signed [DAY_W-1:0] dn_c;
	logic signed [DAY_W-1:0] dn_s6;
	logic [TOD_W-1:0]  sod_s6;

	// Stage 7: week by reciprocal multiply
	logic [DAY_W-2:0]  dpos_c;
	logic [40:0]       w_prod_c;
	logic [WEEK_W-1:0] week_s7;
	logic [DAY_W-2:0]  dlo_s7;
	logic [TOD_W-1:0]  sod_s7;
	logic              neg_s7;

	// Stage 8: second of week
	logic [DAY_W-2:0]  rem_c;
	logic [SOW_W-1:0]  sow_c;
	gps_time_t         gps_s8;

	// Hold the whole pipe while the output word waits
	assign en        = !(valid_s8 && gps_stall);
	assign utc_stall = !en;
	assign gps_valid = valid_s8;
	assign gps       = gps_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s1 <= utc_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// Stage 1 logic
	always_comb begin
		early_c = (utc.month <= 4'd2);
		ya_c    = $signed({1'b0, utc.year} - {12'd0, early_c});
		tod_c   = TOD_W'(utc.hour) * TOD_W'(SEC_PER_HOUR)
			+ TOD_W'(utc.minute) * TOD_W'(SEC_PER_MIN)
			+ TOD_W'(utc.second);
	end

	// Stage 2 logic: a = y/100 (year -1 truncates to 0), yterm = floor(1461*(y+4716)/4)
	always_comb begin
		ya_pos_c = ya_s1[12] ? 12'd0 : ya_s1[11:0];
		a_prod_c = 25'(ya_pos_c) * 25'(DIV100_MUL);
		yb_c     = 14'(15'(ya_s1) + 15'sd4716);
		y_prod_c = 25'(yb_c) * 25'(JDN_YEAR_MUL);
	end

	// Stage 3 logic
	always_comb begin
		day_c = 24'(yterm_s2) + 24'(mterm_s2) + 24'(day_s2) + 24'(a_s2 >> 2)
			- 24'(a_s2) - 24'(DAY_BIAS);
	end

	// Stage 4 logic: the instant passes a leap date once its day, plus any
	// whole day carried in the time of day, reaches the entry
	always_comb begin
		day_eff_c = $signed({day_s3[DAY_W-1], day_s3} + {{DAY_W{1'b0}}, nd_s3});
		for (int i = 0; i < LEAP_TABLE_SIZE; i++) begin
			hit_c[i] = (i < LEAP_USED) && (int'(day_eff_c) >= LEAP_MJD[i] - EPOCH_MJD);
		end
	end

	// Stage 5 logic: last entry reached wins
	always_comb begin
		off_c = TAI_W'(FIRST_TAI_UTC);
		for (int i = 0; i < LEAP_TABLE_SIZE; i++) begin
			if (hit_s4[i]) begin
				off_c = LEAP_TAI_UTC[i];
			end
		end
	end

	// Stage 6 logic: fold the offset into the second of day, carry into the day
	always_comb begin
		sv_c = $signed({1'b0, tod_s5}) + $signed({12'd0, off_s5}) - 18'(TAI_GPS_SEC);
		if (sv_c < 0) begin
			sod_c = TOD_W'(sv_c + 18'(SEC_PER_DAY));
			dn_c  = day_s5 - DAY_W'(1);
		end else if (sv_c >= 18'(SEC_PER_DAY)) begin
			sod_c = TOD_W'(sv_c - 18'(SEC_PER_DAY));
			dn_c  = day_s5 + DAY_W'(1);
		end else begin
			sod_c = TOD_W'(sv_c);
			dn_c  = day_s5;
		end
	end

	// Stage 7 logic
	always_comb begin
		dpos_c   = dn_s6[DAY_W-1] ? '0 : dn_s6[DAY_W-2:0];
		w_prod_c = 41'(dpos_c) * 41'(DIV7_MUL);
	end

	// Stage 8 logic
	always_comb begin
		rem_c = dlo_s7 - (DAY_W-1)'(week_s7) * (DAY_W-1)'(7);
		sow_c = SOW_W'(rem_c[2:0]) * SOW_W'(SEC_PER_DAY) + SOW_W'(sod_s7);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ya_s1    <= ya_c;
			mterm_s1 <= month_term(utc.month);
			day_s1   <= utc.day;
			tod_s1   <= tod_c;

			a_s2     <= a_prod_c[DIV100_SHIFT +: 6];
			yterm_s2 <= y_prod_c[23:2];
			mterm_s2 <= mterm_s1;
			day_s2   <= day_s1;
			tod_s2   <= tod_s1;

			day_s3   <= $signed(day_c[DAY_W-1:0]);
			nd_s3    <= (tod_s2 >= TOD_W'(SEC_PER_DAY));
			tod_s3   <= tod_s2;

			hit_s4   <= hit_c;
			day_s4   <= day_s3;
			tod_s4   <= tod_s3;

			off_s5   <= off_c;
			day_s5   <= day_s4;
			tod_s5   <= tod_s4;

			dn_s6    <= dn_c;
			sod_s6   <= sod_c;

			week_s7  <= w_prod_c[DIV7_SHIFT +: WEEK_W];
			dlo_s7   <= dpos_c;
			sod_s7   <= sod_s6;
			neg_s7   <= dn_s6[DAY_W-1];

			// Zero the result for a time before the epoch
			gps_s8.gps_week     <= neg_s7 ? '0 : week_s7;
			gps_s8.week_second  <= neg_s7 ? '0 : sow_c;
			gps_s8.before_epoch <= neg_s7;
		end
	end

endmodule
